// ===== sv/psf_pkg.sv =====
`default_nettype none

package psf_pkg;

   localparam int FRAC_BITS = 16;
   localparam logic [30:0] FALLBACK_DAMPING = 31'd131;

   localparam int SQRT_STEPS = 32;
   localparam int DIV_STEPS = 32;
   localparam int UNIT_STEPS = FRAC_BITS + 1;

   // Clip bound of the spring scalar, 2^(62-FRAC_BITS)-1.
   localparam logic signed [48:0] S_LIM = (49'sd1 <<< (62 - FRAC_BITS)) - 49'sd1;

   typedef enum logic [2:0] {
      CSR_GRAVITY_X,
      CSR_GRAVITY_Y,
      CSR_GRAVITY_Z,
      CSR_DAMPING_COEFF,
      CSR_FORCE_ENABLES,
      CSR_SPRING_STIFFNESS,
      CSR_SPRING_DAMPING,
      CSR_DRAG_STIFFNESS
   } csr_index_type;

   typedef enum logic [1:0] {
      ACT_PARTICLE,
      ACT_SPRING,
      ACT_DRAG,
      ACT_NONE
   } action_type;

   typedef struct packed {
      action_type       action;
      logic             zero;
      logic [2:0][31:0] early_f;
      logic             early_sat;
      logic             dot_neg;
      logic [47:0]      dm;
      logic [30:0]      rest;
      logic [2:0][31:0] dpm;
      logic [2:0]       dp_neg;
   } carry_type;

   function automatic logic signed [47:0] asr48(input logic signed [63:0] x);
      logic signed [63:0] t;
      t = x >>> FRAC_BITS;
      return $signed(t[47:0]);
   endfunction

   // Returns the clip flag above the clipped 32 bit value.
   function automatic logic [32:0] sat32(input logic signed [49:0] v);
      logic [32:0] r;
      if (v > 50'sd2147483647) begin
         r = {1'b1, 32'h7FFF_FFFF};
      end else if (v < -50'sd2147483648) begin
         r = {1'b1, 32'h8000_0000};
      end else begin
         r = {1'b0, v[31:0]};
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== sv/particle_spring_force_eval.sv =====
`default_nettype none

// Force-term evaluator for a mass-spring particle system in signed Q16.16. One request
// gives one response: a particle term (gravity times inverse mass plus velocity damping),
// a damped spring force, or a drag spring force, each component saturated to 32 bits. The
// pipeline takes one transfer per cycle unless a response stalls; its depth comes from
// the 32-stage square root for the spring length followed by the 32-stage divider that
// normalizes the direction and the damping ratio. A stalled response holds the whole
// pipeline, so nothing is lost or repeated. Configuration registers are written
// via csr_we/csr_index/csr_wdata only while idle; the user ensures this, not the block.
module particle_spring_force_eval (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_ready,
   input  wire         [1:0]  req_action,
   input  wire  signed [31:0] req_pos_dx,
   input  wire  signed [31:0] req_pos_dy,
   input  wire  signed [31:0] req_pos_dz,
   input  wire  signed [31:0] req_vel_x,
   input  wire  signed [31:0] req_vel_y,
   input  wire  signed [31:0] req_vel_z,
   input  wire         [30:0] req_inv_mass,
   input  wire         [30:0] req_rest_length,
   output logic               rsp_valid,
   input  wire                rsp_ready,
   output logic signed [31:0] rsp_force_x,
   output logic signed [31:0] rsp_force_y,
   output logic signed [31:0] rsp_force_z,
   output logic               rsp_zero_length,
   output logic               rsp_saturated,
   input  wire                csr_we,
   input  wire         [2:0]  csr_index,
   input  wire         [31:0] csr_wdata
);

   localparam int NS = psf_pkg::SQRT_STEPS;
   localparam int ND = psf_pkg::DIV_STEPS;

   logic adv;

   logic signed [31:0] cfg_grav_ff [3];
   logic [30:0]        cfg_damp_ff;
   logic [1:0]         cfg_en_ff;
   logic [30:0]        cfg_ks_ff;
   logic [30:0]        cfg_kd_ff;
   logic [30:0]        cfg_drag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_grav_ff[0] <= 32'sd0;
         cfg_grav_ff[1] <= -32'sd13107;
         cfg_grav_ff[2] <= 32'sd0;
         cfg_damp_ff    <= 31'd2621;
         cfg_en_ff      <= 2'd1;
         cfg_ks_ff      <= 31'd327680;
         cfg_kd_ff      <= 31'd6554;
         cfg_drag_ff    <= 31'd5243;
      end else if (csr_we) begin
         unique case (psf_pkg::csr_index_type'(csr_index))
            psf_pkg::CSR_GRAVITY_X:        cfg_grav_ff[0] <= $signed(csr_wdata);
            psf_pkg::CSR_GRAVITY_Y:        cfg_grav_ff[1] <= $signed(csr_wdata);
            psf_pkg::CSR_GRAVITY_Z:        cfg_grav_ff[2] <= $signed(csr_wdata);
            psf_pkg::CSR_DAMPING_COEFF:    cfg_damp_ff    <= csr_wdata[30:0];
            psf_pkg::CSR_FORCE_ENABLES:    cfg_en_ff      <= csr_wdata[1:0];
            psf_pkg::CSR_SPRING_STIFFNESS: cfg_ks_ff      <= csr_wdata[30:0];
            psf_pkg::CSR_SPRING_DAMPING:   cfg_kd_ff      <= csr_wdata[30:0];
            psf_pkg::CSR_DRAG_STIFFNESS:   cfg_drag_ff    <= csr_wdata[30:0];
            default: ;
         endcase
      end
   end

   // The whole pipeline moves whenever the output register is free or being taken.
   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   // Stage A: request register.
   logic                 a_valid_ff;
   psf_pkg::action_type  a_action_ff;
   logic signed [31:0]   a_dp_ff [3];
   logic signed [31:0]   a_v_ff [3];
   logic [30:0]          a_inv_mass_ff;
   logic [30:0]          a_rest_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (adv) begin
         a_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_action_ff   <= psf_pkg::action_type'(req_action);
         a_dp_ff[0]    <= req_pos_dx;
         a_dp_ff[1]    <= req_pos_dy;
         a_dp_ff[2]    <= req_pos_dz;
         a_v_ff[0]     <= req_vel_x;
         a_v_ff[1]     <= req_vel_y;
         a_v_ff[2]     <= req_vel_z;
         a_inv_mass_ff <= req_inv_mass;
         a_rest_ff     <= req_rest_length;
      end
   end

   // Stage B: products.
   logic                 b_valid_ff;
   psf_pkg::action_type  b_action_ff;
   logic                 b_zero_ff;
   logic                 b_zero_in;
   logic signed [31:0]   b_dp_ff [3];
   logic [30:0]          b_rest_ff;
   logic signed [63:0]   b_sq_ff [3];
   logic signed [63:0]   b_vd_ff [3];
   logic signed [63:0]   b_gm_ff [3];
   logic signed [63:0]   b_kv_ff [3];
   logic signed [63:0]   b_dr_ff [3];
   logic signed [63:0]   b_sq_in [3];
   logic signed [63:0]   b_vd_in [3];
   logic signed [63:0]   b_gm_in [3];
   logic signed [63:0]   b_kv_in [3];
   logic signed [63:0]   b_dr_in [3];
   logic [30:0]          k_damp;

   always_comb begin
      k_damp = cfg_en_ff[1] ? cfg_damp_ff : psf_pkg::FALLBACK_DAMPING;
      b_zero_in = (a_action_ff == psf_pkg::ACT_SPRING || a_action_ff == psf_pkg::ACT_DRAG)
                  && a_dp_ff[0] == 32'sd0 && a_dp_ff[1] == 32'sd0 && a_dp_ff[2] == 32'sd0;
      for (int i = 0; i < 3; i++) begin
         b_sq_in[i] = a_dp_ff[i] * a_dp_ff[i];
         b_vd_in[i] = a_v_ff[i] * a_dp_ff[i];
         b_gm_in[i] = cfg_grav_ff[i] * $signed({1'b0, a_inv_mass_ff});
         b_kv_in[i] = 64'sd0 - ($signed({1'b0, k_damp}) * a_v_ff[i]);
         b_dr_in[i] = 64'sd0 - ($signed({1'b0, cfg_drag_ff}) * a_dp_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (adv) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b_action_ff <= a_action_ff;
         b_zero_ff   <= b_zero_in;
         b_rest_ff   <= a_rest_ff;
         for (int i = 0; i < 3; i++) begin
            b_dp_ff[i] <= a_dp_ff[i];
            b_sq_ff[i] <= b_sq_in[i];
            b_vd_ff[i] <= b_vd_in[i];
            b_gm_ff[i] <= b_gm_in[i];
            b_kv_ff[i] <= b_kv_in[i];
            b_dr_ff[i] <= b_dr_in[i];
         end
      end
   end

   // Stage C: sums, particle and drag results, square root operand.
   logic                c_valid_ff;
   psf_pkg::carry_type  c_carry_ff;
   logic [63:0]         c_rad_ff;
   psf_pkg::carry_type  c_carry_in;
   logic [63:0]         c_rad_in;

   always_comb begin
      logic signed [48:0] dot;
      logic signed [47:0] gterm;
      logic [32:0]        r0;
      logic [32:0]        r2;
      logic [2:0][31:0]   f0;
      logic [2:0][31:0]   f2;
      logic               s0;
      logic               s2;
      c_rad_in = 64'd0;
      dot      = 49'sd0;
      s0       = 1'b0;
      s2       = 1'b0;
      for (int i = 0; i < 3; i++) begin
         c_rad_in = c_rad_in + $unsigned(b_sq_ff[i]);
         dot      = dot + 49'(psf_pkg::asr48(b_vd_ff[i]));
         gterm    = cfg_en_ff[0] ? psf_pkg::asr48(b_gm_ff[i]) : 48'sd0;
         r0       = psf_pkg::sat32(50'(gterm) + 50'(psf_pkg::asr48(b_kv_ff[i])));
         r2       = psf_pkg::sat32(50'(psf_pkg::asr48(b_dr_ff[i])));
         f0[i]    = r0[31:0];
         f2[i]    = r2[31:0];
         s0       = s0 | r0[32];
         s2       = s2 | r2[32];
         c_carry_in.dp_neg[i] = b_dp_ff[i] < 32'sd0;
         c_carry_in.dpm[i]    = b_dp_ff[i] < 32'sd0 ? 32'd0 - $unsigned(b_dp_ff[i])
                                                    : $unsigned(b_dp_ff[i]);
      end
      c_carry_in.action  = b_action_ff;
      c_carry_in.zero    = b_zero_ff;
      c_carry_in.rest    = b_rest_ff;
      c_carry_in.dot_neg = dot < 49'sd0;
      c_carry_in.dm      = dot < 49'sd0 ? 48'(49'sd0 - dot) : 48'(dot);
      unique case (b_action_ff)
         psf_pkg::ACT_PARTICLE: begin
            c_carry_in.early_f   = f0;
            c_carry_in.early_sat = s0;
         end
         psf_pkg::ACT_DRAG: begin
            c_carry_in.early_f   = b_zero_ff ? '0 : f2;
            c_carry_in.early_sat = !b_zero_ff && s2;
         end
         default: begin
            c_carry_in.early_f   = '0;
            c_carry_in.early_sat = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (adv) begin
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         c_carry_ff <= c_carry_in;
         c_rad_ff   <= c_rad_in;
      end
   end

   // Square root, one result bit per stage.
   logic                sq_valid_ff [NS];
   psf_pkg::carry_type  sq_carry_ff [NS];
   logic [63:0]         sq_rad_ff [NS];
   logic [33:0]         sq_rem_ff [NS];
   logic [31:0]         sq_root_ff [NS];

   for (genvar j = 0; j < NS; j++) begin : g_sqrt
      logic                valid_p;
      psf_pkg::carry_type  carry_p;
      logic [63:0]         rad_p;
      logic [33:0]         rem_p;
      logic [31:0]         root_p;
      logic [33:0]         shifted;
      logic [33:0]         trial;
      logic                ge;
      logic [33:0]         rem_in;
      logic [31:0]         root_in;

      if (j == 0) begin : g_first
         assign valid_p = c_valid_ff;
         assign carry_p = c_carry_ff;
         assign rad_p   = c_rad_ff;
         assign rem_p   = 34'd0;
         assign root_p  = 32'd0;
      end else begin : g_next
         assign valid_p = sq_valid_ff[j-1];
         assign carry_p = sq_carry_ff[j-1];
         assign rad_p   = sq_rad_ff[j-1];
         assign rem_p   = sq_rem_ff[j-1];
         assign root_p  = sq_root_ff[j-1];
      end

      always_comb begin
         shifted = {rem_p[31:0], rad_p[63:62]};
         trial   = {root_p, 2'b01};
         ge      = shifted >= trial;
         rem_in  = ge ? shifted - trial : shifted;
         root_in = {root_p[30:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_valid_ff[j] <= 1'b0;
         end else if (adv) begin
            sq_valid_ff[j] <= valid_p;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            sq_carry_ff[j] <= carry_p;
            sq_rad_ff[j]   <= {rad_p[61:0], 2'b00};
            sq_rem_ff[j]   <= rem_in;
            sq_root_ff[j]  <= root_in;
         end
      end
   end

   // Stage E: length known; Hooke term and ratio overflow check.
   logic                e_valid_ff;
   psf_pkg::carry_type  e_carry_ff;
   logic [31:0]         e_d_ff;
   logic signed [47:0]  e_h_ff;
   logic                e_rsat_ff;
   logic signed [47:0]  e_h_in;
   logic [31:0]         d_len;

   always_comb begin
      logic signed [33:0] diff;
      logic signed [65:0] hp;
      d_len  = sq_root_ff[NS-1];
      diff   = $signed({2'b00, d_len}) - $signed({3'b000, sq_carry_ff[NS-1].rest});
      hp     = $signed({1'b0, cfg_ks_ff}) * diff;
      e_h_in = psf_pkg::asr48(hp[63:0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
      end else if (adv) begin
         e_valid_ff <= sq_valid_ff[NS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         e_carry_ff <= sq_carry_ff[NS-1];
         e_d_ff     <= d_len;
         e_h_ff     <= e_h_in;
         e_rsat_ff  <= sq_carry_ff[NS-1].dm[47:16] >= d_len;
      end
   end

   // Restoring division: damping ratio over 32 stages, direction components over 17.
   logic                dv_valid_ff [ND];
   psf_pkg::carry_type  dv_carry_ff [ND];
   logic [31:0]         dv_d_ff [ND];
   logic signed [47:0]  dv_h_ff [ND];
   logic                dv_rsat_ff [ND];
   logic [31:0]         dv_num_ff [ND];
   logic [32:0]         dv_rem_ff [ND];
   logic [31:0]         dv_q_ff [ND];
   logic [2:0][16:0]    dv_unum_ff [ND];
   logic [2:0][32:0]    dv_urem_ff [ND];
   logic [2:0][16:0]    dv_uq_ff [ND];

   for (genvar j = 0; j < ND; j++) begin : g_div
      logic                valid_p;
      psf_pkg::carry_type  carry_p;
      logic [31:0]         d_p;
      logic signed [47:0]  h_p;
      logic                rsat_p;
      logic [31:0]         num_p;
      logic [32:0]         rem_p;
      logic [31:0]         q_p;
      logic [2:0][16:0]    unum_p;
      logic [2:0][32:0]    urem_p;
      logic [2:0][16:0]    uq_p;
      logic [32:0]         shifted;
      logic                ge;
      logic [32:0]         rem_in;
      logic [2:0][16:0]    unum_in;
      logic [2:0][32:0]    urem_in;
      logic [2:0][16:0]    uq_in;

      if (j == 0) begin : g_first
         assign valid_p = e_valid_ff;
         assign carry_p = e_carry_ff;
         assign d_p     = e_d_ff;
         assign h_p     = e_h_ff;
         assign rsat_p  = e_rsat_ff;
         assign num_p   = {e_carry_ff.dm[15:0], 16'd0};
         assign rem_p   = {1'b0, e_carry_ff.dm[47:16]};
         assign q_p     = 32'd0;
         for (genvar i = 0; i < 3; i++) begin : g_lane
            assign unum_p[i] = {e_carry_ff.dpm[i][0], 16'd0};
            assign urem_p[i] = {2'b00, e_carry_ff.dpm[i][31:1]};
            assign uq_p[i]   = 17'd0;
         end
      end else begin : g_next
         assign valid_p = dv_valid_ff[j-1];
         assign carry_p = dv_carry_ff[j-1];
         assign d_p     = dv_d_ff[j-1];
         assign h_p     = dv_h_ff[j-1];
         assign rsat_p  = dv_rsat_ff[j-1];
         assign num_p   = dv_num_ff[j-1];
         assign rem_p   = dv_rem_ff[j-1];
         assign q_p     = dv_q_ff[j-1];
         assign unum_p  = dv_unum_ff[j-1];
         assign urem_p  = dv_urem_ff[j-1];
         assign uq_p    = dv_uq_ff[j-1];
      end

      always_comb begin
         logic [32:0] us;
         logic        uge;
         shifted = {rem_p[31:0], num_p[31]};
         ge      = shifted >= {1'b0, d_p};
         rem_in  = ge ? shifted - {1'b0, d_p} : shifted;
         unum_in = unum_p;
         urem_in = urem_p;
         uq_in   = uq_p;
         if (j < psf_pkg::UNIT_STEPS) begin
            for (int i = 0; i < 3; i++) begin
               us         = {urem_p[i][31:0], unum_p[i][16]};
               uge        = us >= {1'b0, d_p};
               urem_in[i] = uge ? us - {1'b0, d_p} : us;
               unum_in[i] = {unum_p[i][15:0], 1'b0};
               uq_in[i]   = {uq_p[i][15:0], uge};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_valid_ff[j] <= 1'b0;
         end else if (adv) begin
            dv_valid_ff[j] <= valid_p;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            dv_carry_ff[j] <= carry_p;
            dv_d_ff[j]     <= d_p;
            dv_h_ff[j]     <= h_p;
            dv_rsat_ff[j]  <= rsat_p;
            dv_num_ff[j]   <= {num_p[30:0], 1'b0};
            dv_rem_ff[j]   <= rem_in;
            dv_q_ff[j]     <= {q_p[30:0], ge};
            dv_unum_ff[j]  <= unum_in;
            dv_urem_ff[j]  <= urem_in;
            dv_uq_ff[j]    <= uq_in;
         end
      end
   end

   // Stage F: damping product.
   logic                f_valid_ff;
   psf_pkg::carry_type  f_carry_ff;
   logic signed [47:0]  f_h_ff;
   logic signed [63:0]  f_dp_ff;
   logic [2:0][16:0]    f_uq_ff;
   logic signed [63:0]  f_dp_in;

   always_comb begin
      logic [31:0] ratio;
      logic [62:0] up;
      ratio   = dv_rsat_ff[ND-1] ? 32'hFFFF_FFFF : dv_q_ff[ND-1];
      up      = 63'(cfg_kd_ff) * 63'(ratio);
      f_dp_in = dv_carry_ff[ND-1].dot_neg ? 64'sd0 - $signed({1'b0, up})
                                          : $signed({1'b0, up});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else if (adv) begin
         f_valid_ff <= dv_valid_ff[ND-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         f_carry_ff <= dv_carry_ff[ND-1];
         f_h_ff     <= dv_h_ff[ND-1];
         f_dp_ff    <= f_dp_in;
         f_uq_ff    <= dv_uq_ff[ND-1];
      end
   end

   // Stage G: spring scalar with clip, signed unit vector.
   logic                g_valid_ff;
   psf_pkg::carry_type  g_carry_ff;
   logic signed [46:0]  g_s_ff;
   logic                g_ssat_ff;
   logic signed [17:0]  g_u_ff [3];
   logic signed [46:0]  g_s_in;
   logic                g_ssat_in;
   logic signed [17:0]  g_u_in [3];

   always_comb begin
      logic signed [48:0] s;
      logic signed [17:0] um;
      s         = 49'(f_h_ff) + 49'(psf_pkg::asr48(f_dp_ff));
      g_ssat_in = 1'b0;
      if (s > psf_pkg::S_LIM) begin
         s         = psf_pkg::S_LIM;
         g_ssat_in = 1'b1;
      end else if (s < -psf_pkg::S_LIM) begin
         s         = -psf_pkg::S_LIM;
         g_ssat_in = 1'b1;
      end
      g_s_in = s[46:0];
      for (int i = 0; i < 3; i++) begin
         um        = $signed({1'b0, f_uq_ff[i]});
         g_u_in[i] = f_carry_ff.dp_neg[i] ? 18'sd0 - um : um;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         g_valid_ff <= 1'b0;
      end else if (adv) begin
         g_valid_ff <= f_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         g_carry_ff <= f_carry_ff;
         g_s_ff     <= g_s_in;
         g_ssat_ff  <= g_ssat_in;
         for (int i = 0; i < 3; i++) begin
            g_u_ff[i] <= g_u_in[i];
         end
      end
   end

   // Stage H: force products.
   logic                h_valid_ff;
   psf_pkg::carry_type  h_carry_ff;
   logic                h_ssat_ff;
   logic signed [63:0]  h_p_ff [3];
   logic signed [63:0]  h_p_in [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         h_p_in[i] = 64'sd0 - (g_s_ff * g_u_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         h_valid_ff <= 1'b0;
      end else if (adv) begin
         h_valid_ff <= g_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         h_carry_ff <= g_carry_ff;
         h_ssat_ff  <= g_ssat_ff;
         for (int i = 0; i < 3; i++) begin
            h_p_ff[i] <= h_p_in[i];
         end
      end
   end

   // Output register.
   logic                o_valid_ff;
   logic [2:0][31:0]    o_f_ff;
   logic                o_zero_ff;
   logic                o_sat_ff;
   logic [2:0][31:0]    o_f_in;
   logic                o_sat_in;

   always_comb begin
      logic [32:0] r;
      logic        sp;
      sp = h_ssat_ff;
      for (int i = 0; i < 3; i++) begin
         r         = psf_pkg::sat32(50'(psf_pkg::asr48(h_p_ff[i])));
         o_f_in[i] = r[31:0];
         sp        = sp | r[32];
      end
      if (h_carry_ff.action == psf_pkg::ACT_SPRING && !h_carry_ff.zero) begin
         o_sat_in = sp;
      end else begin
         o_f_in   = h_carry_ff.early_f;
         o_sat_in = h_carry_ff.early_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         o_valid_ff <= 1'b0;
      end else if (adv) begin
         o_valid_ff <= h_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         o_f_ff    <= o_f_in;
         o_zero_ff <= h_carry_ff.zero;
         o_sat_ff  <= o_sat_in;
      end
   end

   assign rsp_valid       = o_valid_ff;
   assign rsp_force_x     = $signed(o_f_ff[0]);
   assign rsp_force_y     = $signed(o_f_ff[1]);
   assign rsp_force_z     = $signed(o_f_ff[2]);
   assign rsp_zero_length = o_zero_ff;
   assign rsp_saturated   = o_sat_ff;

endmodule

`default_nettype wire

// ===== sim/particle_spring_force_eval_checker.sv =====
`default_nettype none

module particle_spring_force_eval_checker (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   input  wire                req_ready,
   input  wire         [1:0]  req_action,
   input  wire  signed [31:0] req_pos_dx,
   input  wire  signed [31:0] req_pos_dy,
   input  wire  signed [31:0] req_pos_dz,
   input  wire  signed [31:0] req_vel_x,
   input  wire  signed [31:0] req_vel_y,
   input  wire  signed [31:0] req_vel_z,
   input  wire         [30:0] req_inv_mass,
   input  wire         [30:0] req_rest_length,
   input  wire                rsp_valid,
   input  wire                rsp_ready,
   input  wire  signed [31:0] rsp_force_x,
   input  wire  signed [31:0] rsp_force_y,
   input  wire  signed [31:0] rsp_force_z,
   input  wire                rsp_zero_length,
   input  wire                rsp_saturated,
   input  wire                csr_we,
   input  wire         [2:0]  csr_index,
   input  wire         [31:0] csr_wdata,
   output int                 error_count,
   output int                 pending_count
);

   timeunit 1ns;
   timeprecision 1ps;

   typedef logic signed [127:0] wide_type;

   typedef struct {
      logic signed [31:0] fx;
      logic signed [31:0] fy;
      logic signed [31:0] fz;
      logic               zero_len;
      logic               sat;
   } force_type;

   logic signed [31:0] grav_x, grav_y, grav_z;
   logic [30:0] damp_k, ks, kd, kdrag;
   logic [1:0] enables;
   force_type expected_forces[$];

   function automatic logic [63:0] root64(input logic [63:0] x);
      logic [63:0] rem, r, b;
      rem = x;
      r = 0;
      b = 64'h4000_0000_0000_0000;
      while (b > rem) b = b >> 2;
      while (b != 0) begin
         if (rem >= r + b) begin
            rem = rem - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic logic signed [31:0] clip32(input wide_type v, inout logic flag);
      if (v > wide_type'(64'sh7FFF_FFFF)) begin
         flag = 1'b1;
         return 32'h7FFF_FFFF;
      end
      if (v < -wide_type'(64'sh8000_0000)) begin
         flag = 1'b1;
         return 32'h8000_0000;
      end
      return v[31:0];
   endfunction

   function automatic force_type predict_force(input logic [1:0] act,
                                               input logic signed [31:0] dx, dy, dz,
                                               input logic signed [31:0] vx, vy, vz,
                                               input logic [30:0] im, rest);
      wide_type dp[3], v[3], g[3], f[3];
      wide_type k, d, h, dot, dm, rm, ratio, s, lim, u;
      logic [63:0] sq;
      force_type r;
      logic sat;
      dp[0] = wide_type'(dx); dp[1] = wide_type'(dy); dp[2] = wide_type'(dz);
      v[0] = wide_type'(vx); v[1] = wide_type'(vy); v[2] = wide_type'(vz);
      g[0] = wide_type'(grav_x); g[1] = wide_type'(grav_y); g[2] = wide_type'(grav_z);
      f[0] = 0; f[1] = 0; f[2] = 0;
      sat = 1'b0;
      r.zero_len = 1'b0;
      if (act == psf_pkg::ACT_PARTICLE) begin
         k = enables[1] ? wide_type'($unsigned(damp_k))
                        : wide_type'($unsigned(psf_pkg::FALLBACK_DAMPING));
         for (int i = 0; i < 3; i++) begin
            f[i] = (-(k * v[i])) >>> psf_pkg::FRAC_BITS;
            if (enables[0])
               f[i] = f[i] + ((g[i] * wide_type'($unsigned(im))) >>> psf_pkg::FRAC_BITS);
         end
      end else if (act == psf_pkg::ACT_SPRING || act == psf_pkg::ACT_DRAG) begin
         if (dp[0] == 0 && dp[1] == 0 && dp[2] == 0) begin
            r.zero_len = 1'b1;
         end else if (act == psf_pkg::ACT_DRAG) begin
            for (int i = 0; i < 3; i++)
               f[i] = (-(wide_type'($unsigned(kdrag)) * dp[i])) >>> psf_pkg::FRAC_BITS;
         end else begin
            sq = 0;
            for (int i = 0; i < 3; i++) sq = sq + 64'(dp[i] * dp[i]);
            d = wide_type'($unsigned(root64(sq)));
            h = (wide_type'($unsigned(ks)) * (d - wide_type'($unsigned(rest))))
                >>> psf_pkg::FRAC_BITS;
            dot = 0;
            for (int i = 0; i < 3; i++) dot = dot + ((v[i] * dp[i]) >>> psf_pkg::FRAC_BITS);
            dm = dot < 0 ? -dot : dot;
            rm = (dm <<< psf_pkg::FRAC_BITS) / d;
            if (rm > wide_type'(64'sh0_FFFF_FFFF)) rm = wide_type'(64'sh0_FFFF_FFFF);
            ratio = dot < 0 ? -rm : rm;
            s = h + ((wide_type'($unsigned(kd)) * ratio) >>> psf_pkg::FRAC_BITS);
            lim = (wide_type'(1) <<< (62 - psf_pkg::FRAC_BITS)) - 1;
            if (s > lim) begin
               s = lim;
               sat = 1'b1;
            end
            if (s < -lim) begin
               s = -lim;
               sat = 1'b1;
            end
            for (int i = 0; i < 3; i++) begin
               u = ((dp[i] < 0 ? -dp[i] : dp[i]) <<< psf_pkg::FRAC_BITS) / d;
               if (dp[i] < 0) u = -u;
               f[i] = (-(s * u)) >>> psf_pkg::FRAC_BITS;
            end
         end
      end
      r.fx = clip32(f[0], sat);
      r.fy = clip32(f[1], sat);
      r.fz = clip32(f[2], sat);
      r.sat = sat;
      return r;
   endfunction

   assign pending_count = expected_forces.size();

   always @(posedge clock) begin
      force_type e;
      if (reset) begin
         grav_x <= 0;
         grav_y <= -32'sd13107;
         grav_z <= 0;
         damp_k <= 31'd2621;
         enables <= 2'd1;
         ks <= 31'd327680;
         kd <= 31'd6554;
         kdrag <= 31'd5243;
         error_count <= 0;
         expected_forces.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               psf_pkg::CSR_GRAVITY_X: grav_x <= csr_wdata;
               psf_pkg::CSR_GRAVITY_Y: grav_y <= csr_wdata;
               psf_pkg::CSR_GRAVITY_Z: grav_z <= csr_wdata;
               psf_pkg::CSR_DAMPING_COEFF: damp_k <= csr_wdata[30:0];
               psf_pkg::CSR_FORCE_ENABLES: enables <= csr_wdata[1:0];
               psf_pkg::CSR_SPRING_STIFFNESS: ks <= csr_wdata[30:0];
               psf_pkg::CSR_SPRING_DAMPING: kd <= csr_wdata[30:0];
               psf_pkg::CSR_DRAG_STIFFNESS: kdrag <= csr_wdata[30:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            expected_forces.push_back(predict_force(req_action, req_pos_dx, req_pos_dy,
               req_pos_dz, req_vel_x, req_vel_y, req_vel_z, req_inv_mass, req_rest_length));
         if (rsp_valid && rsp_ready) begin
            if (expected_forces.size() == 0) begin
               $display("%0t: response transfer with nothing expected", $time);
               error_count <= error_count + 1;
            end else begin
               e = expected_forces.pop_front();
               if (e.fx !== rsp_force_x || e.fy !== rsp_force_y || e.fz !== rsp_force_z ||
                   e.zero_len !== rsp_zero_length || e.sat !== rsp_saturated) begin
                  $display("%0t: expected f=(%0d,%0d,%0d) zl=%0b sat=%0b", $time,
                     e.fx, e.fy, e.fz, e.zero_len, e.sat);
                  $display("%0t: actual   f=(%0d,%0d,%0d) zl=%0b sat=%0b", $time,
                     rsp_force_x, rsp_force_y, rsp_force_z, rsp_zero_length,
                     rsp_saturated);
                  error_count <= error_count + 1;
               end
            end
         end
      end
   end

endmodule

`default_nettype wire

// ===== sim/particle_spring_force_eval_tb.sv =====
`default_nettype none

module particle_spring_force_eval_tb;

   timeunit 1ns;
   timeprecision 1ps;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [1:0] req_action = psf_pkg::ACT_PARTICLE;
   logic signed [31:0] req_pos_dx = 0, req_pos_dy = 0, req_pos_dz = 0;
   logic signed [31:0] req_vel_x = 0, req_vel_y = 0, req_vel_z = 0;
   logic [30:0] req_inv_mass = 0, req_rest_length = 0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [31:0] rsp_force_x, rsp_force_y, rsp_force_z;
   logic rsp_zero_length, rsp_saturated;
   logic csr_we = 1'b0;
   logic [2:0] csr_index = psf_pkg::CSR_GRAVITY_X;
   logic [31:0] csr_wdata = 0;
   int error_count, pending_count;
   int send_idle_pct = 21, recv_idle_pct = 58;
   int item_count = 0;
   logic hold_go = 1'b0;
   int hold_left = 0;

   particle_spring_force_eval dut (.*);
   particle_spring_force_eval_checker checker_i (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #5ms;
      $display("particle_spring_force_eval: mismatch");
      $finish;
   end

   initial begin
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left = hold_left - 1;
            rsp_ready <= 1'b0;
         end else if (hold_go) begin
            hold_go = 1'b0;
            hold_left = 300;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= !reset && ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   function automatic logic [31:0] pick_value();
      logic [31:0] v;
      case ($urandom_range(0, 6))
         0, 1: v = $urandom;
         2: v = $urandom_range(0, 32'h0010_0000);
         3: v = 32'h8000_0000;
         4: v = 32'h7FFF_FFFF;
         5: v = 0;
         default: v = $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
      endcase
      if ($urandom_range(0, 1)) v = -v;
      return v;
   endfunction

   task automatic send_force_term(input logic [1:0] act, input logic [31:0] dx, dy, dz,
                                  input logic [31:0] vx, vy, vz, input logic [30:0] im,
                                  input logic [30:0] rest);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_action <= act;
      req_pos_dx <= dx;
      req_pos_dy <= dy;
      req_pos_dz <= dz;
      req_vel_x <= vx;
      req_vel_y <= vy;
      req_vel_z <= vz;
      req_inv_mass <= im;
      req_rest_length <= rest;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      item_count++;
   endtask

   task automatic send_random_term();
      logic [1:0] act;
      logic [31:0] dx, dy, dz;
      act = ($urandom_range(0, 19) == 0) ? psf_pkg::ACT_NONE : 2'($urandom_range(0, 2));
      dx = pick_value();
      dy = pick_value();
      dz = pick_value();
      if (act != psf_pkg::ACT_PARTICLE && $urandom_range(0, 9) == 0) begin
         dx = 0;
         dy = 0;
         dz = 0;
      end
      send_force_term(act, dx, dy, dz, pick_value(), pick_value(), pick_value(),
                      31'(pick_value()), 31'(pick_value()));
   endtask

   task automatic write_reg(input psf_pkg::csr_index_type idx, input logic [31:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic drain_responses();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_force_term(psf_pkg::ACT_PARTICLE, 0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 0,
                      31'h7FFF_FFFF, 0);
      send_force_term(psf_pkg::ACT_PARTICLE, 0, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF,
                      32'hFFFF_FFFF, 0, 31'h7FFF_FFFF);
      send_force_term(psf_pkg::ACT_SPRING, 0, 0, 0, 32'h0001_0000, 0, 0, 0, 31'h0001_0000);
      send_force_term(psf_pkg::ACT_DRAG, 0, 0, 0, 32'h7FFF_FFFF, 0, 0, 0, 0);
      send_force_term(psf_pkg::ACT_SPRING, 32'h0001_0000, 0, 0, 32'h0000_8000, 0, 0, 0,
                      31'h8000);
      send_force_term(psf_pkg::ACT_SPRING, 1, 0, 0, 32'h7FFF_FFFF, 0, 0, 0, 31'h7FFF_FFFF);
      send_force_term(psf_pkg::ACT_SPRING, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                      32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0);
      send_force_term(psf_pkg::ACT_SPRING, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                      32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 31'h7FFF_FFFF);
      send_force_term(psf_pkg::ACT_SPRING, 0, 32'hFFFF_0000, 0, 0, 32'h0002_0000, 0, 0,
                      31'h0002_0000);
      send_force_term(psf_pkg::ACT_DRAG, 32'h7FFF_FFFF, 32'h8000_0000, 1, 0, 0, 0, 0, 0);
      send_force_term(psf_pkg::ACT_DRAG, 32'h8000_0000, 0, 32'hFFFF_FFFF, 0, 0, 0, 0, 0);
      send_force_term(psf_pkg::ACT_NONE, 32'h7FFF_FFFF, 1, 2, 3, 4, 5, 31'h7FFF_FFFF,
                      31'h7FFF_FFFF);
      send_force_term(psf_pkg::ACT_NONE, 0, 0, 0, 0, 0, 0, 0, 0);

      for (int phase = 0; phase < 6; phase++) begin
         send_idle_pct = phase < 2 ? 21 : (phase < 4 ? 58 : 0);
         recv_idle_pct = phase < 2 ? 58 : (phase < 4 ? 21 : 0);
         case (phase)
            1: begin
               for (int r = 0; r < 8; r++) write_reg(psf_pkg::csr_index_type'(r), $urandom);
            end
            2: begin
               for (int r = 0; r < 3; r++)
                  write_reg(psf_pkg::csr_index_type'(r), 32'h7FFF_FFFF);
               write_reg(psf_pkg::CSR_DAMPING_COEFF, 32'h7FFF_FFFF);
               write_reg(psf_pkg::CSR_FORCE_ENABLES, 32'd3);
               write_reg(psf_pkg::CSR_SPRING_STIFFNESS, 32'h7FFF_FFFF);
               write_reg(psf_pkg::CSR_SPRING_DAMPING, 32'h7FFF_FFFF);
               write_reg(psf_pkg::CSR_DRAG_STIFFNESS, 32'h7FFF_FFFF);
            end
            3: begin
               for (int r = 0; r < 3; r++)
                  write_reg(psf_pkg::csr_index_type'(r), 32'h8000_0000);
               for (int r = 3; r < 8; r++) write_reg(psf_pkg::csr_index_type'(r), 32'd0);
            end
            4: begin
               write_reg(psf_pkg::CSR_GRAVITY_Y, -32'sd9000 - $urandom_range(0, 20000));
               write_reg(psf_pkg::CSR_DAMPING_COEFF, $urandom_range(0, 32'h0002_0000));
               write_reg(psf_pkg::CSR_FORCE_ENABLES, 32'd2);
               write_reg(psf_pkg::CSR_SPRING_STIFFNESS, $urandom_range(0, 32'h0010_0000));
               write_reg(psf_pkg::CSR_SPRING_DAMPING, $urandom_range(0, 32'h0001_0000));
            end
            5: begin
               for (int r = 0; r < 8; r++)
                  write_reg(psf_pkg::csr_index_type'(r), pick_value());
            end
            default: ;
         endcase
         csr_we <= 1'b0;
         for (int n = 0; n < 90; n++) begin
            if (phase == 1 && n == 30) hold_go = 1'b1;
            send_random_term();
         end
         drain_responses();
      end

      $display("Sent %0d force terms over six register settings, including extremes,", item_count);
      $display("with both sides idling at random and one long response stall.");
      if (error_count == 0) begin
         $display("particle_spring_force_eval: match");
      end else begin
         $display("particle_spring_force_eval: mismatch");
      end
      $finish;
   end

endmodule

`default_nettype wire
